// File: src/assert_macros.svh
// Assertion macros shared by the polygon normal RTL.
// Uses clk and rst of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, masked during reset.
`define PNN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent this cycle, consequent on the next.
`define PNN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pnn_pkg.sv
// Types and constants of the Newell polygon normal block.
// No dependencies.
`default_nettype none

package pnn_pkg;

  localparam int COORD_W     = 24;   // port width of a coordinate
  localparam int ACC_W       = 58;   // Newell accumulator, Q34.24
  localparam int PROD_W      = 2 * (COORD_W + 1);
  localparam int MAG_W       = 30;   // normalised magnitude
  localparam int SQ_W        = 64;   // square sum and root working width
  localparam int LEN_W       = 32;   // vector length
  localparam int QUO_W       = 17;   // per-component quotient
  localparam int NUM_W       = MAG_W + 15 + 1;
  localparam int OUT_W       = 16;
  localparam int Q15_MAX     = 32767;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic                    sat;
  } pnn_acc_t;

  typedef enum logic [1:0] {
    F_TAKE,
    F_MUL,
    F_ADD,
    F_PUSH
  } pnn_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAG,
    B_SHIFT,
    B_SQ,
    B_SQRT,
    B_LOAD,
    B_DIV,
    B_OUT
  } pnn_back_state_t;

endpackage

`default_nettype wire

// File: src/pnn_if.sv
// Valid/ready channel interfaces: vertex input and normal output.
// Depends on pnn_pkg.
`default_nettype none

interface pnn_vtx_if;
  logic                               valid;
  logic                               ready;
  logic signed [pnn_pkg::COORD_W-1:0] pos_x;
  logic signed [pnn_pkg::COORD_W-1:0] pos_y;
  logic signed [pnn_pkg::COORD_W-1:0] pos_z;
  logic                               last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

interface pnn_nrm_if;
  logic                             valid;
  logic                             ready;
  logic signed [pnn_pkg::OUT_W-1:0] normal_x;
  logic signed [pnn_pkg::OUT_W-1:0] normal_y;
  logic signed [pnn_pkg::OUT_W-1:0] normal_z;
  logic                             degenerate;
  logic                             saturated;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, saturated,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, saturated,
                  output ready);
endinterface

`default_nettype wire

// File: src/pnn_front.sv
// Front end: takes vertex beats and accumulates the Newell cross terms.
// Depends on pnn_pkg and pnn_vtx_if.
`default_nettype none

module pnn_front #(
  parameter int COORD_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  pnn_vtx_if.sink           vtx,
  output pnn_pkg::pnn_acc_t push_data,
  output logic              push,
  input  logic              full
);
  import pnn_pkg::*;

  localparam int SHIFT = COORD_W - COORD_BITS;

  pnn_front_state_t state, state_next;

  logic signed [COORD_W-1:0] cur   [3];
  logic signed [COORD_W-1:0] first [3];
  logic signed [COORD_W-1:0] prev  [3];
  logic signed [COORD_W-1:0] opa   [3];
  logic signed [COORD_W-1:0] opb   [3];
  logic signed [COORD_W:0]   dif   [3];
  logic signed [COORD_W:0]   smm   [3];
  logic signed [PROD_W-1:0]  prod  [3];
  logic signed [ACC_W-1:0]   acc   [3];
  logic [ACC_W:0]            add_r [3];
  logic                      sat;
  logic                      in_poly;
  logic                      close_pend;
  logic                      finish;
  logic                      accept;

  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                             input logic signed [PROD_W-1:0] t);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(t);
    if (s[ACC_W] != s[ACC_W-1]) return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  // narrow coordinates are sign extended from COORD_BITS
  assign cur[0] = (vtx.pos_x <<< SHIFT) >>> SHIFT;
  assign cur[1] = (vtx.pos_y <<< SHIFT) >>> SHIFT;
  assign cur[2] = (vtx.pos_z <<< SHIFT) >>> SHIFT;

  assign accept = vtx.valid && vtx.ready;

  // axis k uses the other two axes: x <- (y, z), y <- (z, x), z <- (x, y)
  always_comb begin
    dif[0] = {opa[1][COORD_W-1], opa[1]} - {opb[1][COORD_W-1], opb[1]};
    smm[0] = {opa[2][COORD_W-1], opa[2]} + {opb[2][COORD_W-1], opb[2]};
    dif[1] = {opa[2][COORD_W-1], opa[2]} - {opb[2][COORD_W-1], opb[2]};
    smm[1] = {opa[0][COORD_W-1], opa[0]} + {opb[0][COORD_W-1], opb[0]};
    dif[2] = {opa[0][COORD_W-1], opa[0]} - {opb[0][COORD_W-1], opb[0]};
    smm[2] = {opa[1][COORD_W-1], opa[1]} + {opb[1][COORD_W-1], opb[1]};
    for (int k = 0; k < 3; k++) add_r[k] = sat_add(acc[k], prod[k]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_TAKE: if (accept && (in_poly || vtx.last_vertex)) state_next = F_MUL;
      F_MUL:  state_next = F_ADD;
      F_ADD: begin
        if (close_pend)  state_next = F_MUL;
        else if (finish) state_next = F_PUSH;
        else             state_next = F_TAKE;
      end
      F_PUSH: if (!full) state_next = F_TAKE;
      default: state_next = F_TAKE;
    endcase
  end

  always_comb begin
    vtx.ready = (state == F_TAKE);
    push      = (state == F_PUSH) && !full;
    push_data = '{ax: acc[0], ay: acc[1], az: acc[2], sat: sat};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_TAKE;
      in_poly    <= 1'b0;
      sat        <= 1'b0;
      close_pend <= 1'b0;
      finish     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        F_TAKE: if (accept) begin
          prev <= cur;
          if (!in_poly) begin
            first      <= cur;
            acc        <= '{default: '0};
            sat        <= 1'b0;
            in_poly    <= 1'b1;
            opa        <= cur;
            opb        <= cur;
            close_pend <= 1'b0;
            finish     <= vtx.last_vertex;
          end else begin
            opa        <= prev;
            opb        <= cur;
            close_pend <= vtx.last_vertex;
            finish     <= vtx.last_vertex;
          end
        end
        F_MUL: for (int k = 0; k < 3; k++) prod[k] <= dif[k] * smm[k];
        F_ADD: begin
          for (int k = 0; k < 3; k++) acc[k] <= add_r[k][ACC_W-1:0];
          sat <= sat | add_r[0][ACC_W] | add_r[1][ACC_W] | add_r[2][ACC_W];
          if (close_pend) begin
            opa        <= opb;
            opb        <= first;
            close_pend <= 1'b0;
          end
        end
        F_PUSH: if (!full) begin
          in_poly <= 1'b0;
          finish  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/pnn_queue.sv
// Two-entry queue carrying finished Newell sums from front to back end.
// Depends on pnn_pkg.
`default_nettype none

module pnn_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pnn_pkg::pnn_acc_t push_data,
  output logic              full,
  input  logic              pop,
  output pnn_pkg::pnn_acc_t pop_data,
  output logic              empty
);
  import pnn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pnn_acc_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/pnn_back.sv
// Back end: normalises a Newell sum to a Q1.15 unit vector with a
// shift-per-cycle normaliser, bit-serial square root and divider.
// Depends on pnn_pkg and pnn_nrm_if.
`default_nettype none

module pnn_back (
  input  logic              clk,
  input  logic              rst,
  input  pnn_pkg::pnn_acc_t pop_data,
  input  logic              empty,
  output logic              pop,
  pnn_nrm_if.source         nrm
);
  import pnn_pkg::*;

  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (SQ_W - 2);

  pnn_back_state_t state, state_next;

  logic signed [ACC_W-1:0] accr  [3];
  logic [ACC_W-1:0]        mag   [3];
  logic                    neg   [3];
  logic [ACC_W-1:0]        mx;
  logic [ACC_W-1:0]        mag_c [3];
  logic [ACC_W-1:0]        mx_c;
  logic [1:0]              cnt;
  logic [2*MAG_W-1:0]      prod;
  logic [SQ_W-1:0]         sq_v;
  logic [SQ_W-1:0]         sq_res;
  logic [SQ_W-1:0]         sq_bit;
  logic [SQ_W-1:0]         sq_try;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        rem;
  logic [QUO_W-1:0]        nsh;
  logic [QUO_W-1:0]        quo;
  logic [LEN_W:0]          dtry;
  logic                    qbit;
  logic [QUO_W-1:0]        quo_new;
  logic [OUT_W-2:0]        qclip;
  logic signed [OUT_W-1:0] qval;
  logic [NUM_W-1:0]        num;
  logic [4:0]              dcnt;
  logic signed [OUT_W-1:0] nout  [3];
  logic                    deg;
  logic                    satr;
  logic                    sqrt_done;
  logic                    shift_done;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = accr[k][ACC_W-1] ? ACC_W'(-accr[k]) : ACC_W'(accr[k]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  // the root is final in sq_res from the first load onwards
  assign shift_done = (mx[ACC_W-1:MAG_W] == '0) && mx[MAG_W-1];
  assign sq_try     = sq_res + sq_bit;
  assign sqrt_done  = sq_bit[0];
  assign num        = NUM_W'({mag[cnt][MAG_W-1:0], 15'b0}) + NUM_W'(sq_res[LEN_W-1:0] >> 1);
  assign dtry       = {rem, nsh[QUO_W-1]};
  assign qbit       = (dtry >= {1'b0, len});
  assign quo_new    = {quo[QUO_W-2:0], qbit};
  assign qclip      = (quo_new > QUO_W'(Q15_MAX)) ? (OUT_W-1)'(Q15_MAX)
                                                  : quo_new[OUT_W-2:0];
  assign qval       = neg[cnt] ? -$signed({1'b0, qclip}) : $signed({1'b0, qclip});

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!empty) state_next = B_MAG;
      B_MAG:   state_next = (mx_c == '0) ? B_OUT : B_SHIFT;
      B_SHIFT: if (shift_done) state_next = B_SQ;
      B_SQ:    if (cnt == 2'd3) state_next = B_SQRT;
      B_SQRT:  if (sqrt_done) state_next = B_LOAD;
      B_LOAD:  state_next = B_DIV;
      B_DIV: begin
        if (dcnt == 5'(QUO_W - 1)) state_next = (cnt == 2'd2) ? B_OUT : B_LOAD;
      end
      B_OUT:   if (nrm.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop            = (state == B_IDLE) && !empty;
    nrm.valid      = (state == B_OUT);
    nrm.normal_x   = nout[0];
    nrm.normal_y   = nout[1];
    nrm.normal_z   = nout[2];
    nrm.degenerate = deg;
    nrm.saturated  = satr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
      unique case (state)
        B_IDLE: if (!empty) begin
          accr[0] <= pop_data.ax;
          accr[1] <= pop_data.ay;
          accr[2] <= pop_data.az;
          satr    <= pop_data.sat;
        end
        B_MAG: begin
          mag <= mag_c;
          mx  <= mx_c;
          for (int k = 0; k < 3; k++) neg[k] <= accr[k][ACC_W-1];
          deg <= (mx_c == '0);
          if (mx_c == '0) begin
            nout[0] <= '0;
            nout[1] <= OUT_W'(Q15_MAX);
            nout[2] <= '0;
          end
        end
        B_SHIFT: begin
          cnt  <= '0;
          sq_v <= '0;
          if (mx[ACC_W-1:MAG_W] != '0) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
            mx <= mx >> 1;
          end else if (!mx[MAG_W-1]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
            mx <= mx << 1;
          end
        end
        B_SQ: begin
          // one square per cycle, each summed into sq_v in the next cycle
          if (cnt != 2'd3) prod <= mag[cnt][MAG_W-1:0] * mag[cnt][MAG_W-1:0];
          if (cnt != 2'd0) sq_v <= sq_v + SQ_W'(prod);
          cnt    <= cnt + 1'b1;
          sq_res <= '0;
          sq_bit <= SQ_TOP;
        end
        B_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= '0;
        end
        B_LOAD: begin
          if (len == '0) len <= sq_res[LEN_W-1:0];
          rem  <= LEN_W'(num[NUM_W-1:QUO_W]);
          nsh  <= num[QUO_W-1:0];
          quo  <= '0;
          dcnt <= '0;
        end
        B_DIV: begin
          rem  <= qbit ? LEN_W'(dtry - {1'b0, len}) : dtry[LEN_W-1:0];
          nsh  <= nsh << 1;
          quo  <= quo_new;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'(QUO_W - 1)) begin
            nout[cnt] <= qval;
            cnt       <= cnt + 1'b1;
          end
        end
        B_OUT: len <= '0;
        default: ;
      endcase
      if (state == B_SQRT && sqrt_done) len <= '0;
    end
  end

endmodule

`default_nettype wire

// File: src/polygon_normal_newell.sv
// Top level of the Newell polygon normal block.
// Depends on pnn_pkg, pnn_if, pnn_front, pnn_queue, pnn_back, assert_macros.svh.
//
//   channel | dir | payload                                          | beat
//   vtx     | in  | pos_x, pos_y, pos_z (Q12.12), last_vertex        | one vertex
//   nrm     | out | normal_x/y/z (Q1.15), degenerate, saturated      | one normal
//
// Front: the opening vertex of a polygon is only taken; each later vertex is
// taken, multiplied and accumulated. The closing vertex adds a second
// multiply/accumulate pass for the closing pair and a push of the sum, held
// while the queue is full. A lone closing vertex is taken, multiplied,
// accumulated and pushed. Back: the sum is taken and classified, normalised
// by up to 29 one-bit shifts and a final check, squared per component, rooted
// in 32 bit-serial root steps and divided per component by a bit-serial
// divider, then held in the output beat; a zero sum goes straight to output.
// The two-entry queue lets vertices keep flowing while the back end works or
// the output beat stalls.
// Reset is synchronous (rst high) and clears control state only.
`default_nettype none
`include "assert_macros.svh"

module polygon_normal_newell #(
  parameter int COORD_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  pnn_vtx_if.sink   vtx,
  pnn_nrm_if.source nrm
);
  import pnn_pkg::*;

  pnn_acc_t q_push_data;
  pnn_acc_t q_pop_data;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  logic     fallback_ok;

  // vertex accumulation
  pnn_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .push_data (q_push_data),
    .push      (q_push),
    .full      (q_full)
  );

  // decoupling between accumulation and normalisation
  pnn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // normalisation and output register
  pnn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (q_pop_data),
    .empty    (q_empty),
    .pop      (q_pop),
    .nrm      (nrm)
  );

  // fallback normal is (0, 1, 0)
  assign fallback_ok = (nrm.normal_x == '0) && (nrm.normal_y == OUT_W'(Q15_MAX)) &&
                       (nrm.normal_z == '0);

  `PNN_ASSERT(a_no_overflow, q_push |-> !q_full, "queue written while full")
  `PNN_ASSERT(a_fallback, (nrm.valid && nrm.degenerate) |-> fallback_ok, "bad fallback normal")
  `PNN_ASSERT_NEXT(a_pop_leaves_idle, q_pop, !q_pop, "back end popped twice in a row")

endmodule

`default_nettype wire

// File: sim/polygon_normal_newell_tb.sv
// Self-checking testbench for the Newell polygon normal block.
// Depends on pnn_pkg, pnn_if and the polygon_normal_newell RTL.
`timescale 1ns / 100ps

// Expected normals are predicted from each accepted vertex and checked in order.
class normal_scoreboard;
  typedef struct {
    logic signed [pnn_pkg::OUT_W-1:0] nx;
    logic signed [pnn_pkg::OUT_W-1:0] ny;
    logic signed [pnn_pkg::OUT_W-1:0] nz;
    logic                             degen;
    logic                             sat;
  } normal_t;

  localparam longint ACC_HI = (64'sd1 <<< 57) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  normal_t expected_normals[$];
  longint  first_v[3];
  longint  prev_v[3];
  longint  acc[3];
  bit      open_poly;
  bit      sat_sticky;
  int      errors;
  int      n_polys;
  int      n_degen;
  int      n_sat;

  function void add_term(int k, longint term);
    longint s;
    s = acc[k] + term;
    if (s > ACC_HI) begin
      s = ACC_HI;
      sat_sticky = 1;
    end
    if (s < ACC_LO) begin
      s = ACC_LO;
      sat_sticky = 1;
    end
    acc[k] = s;
  endfunction

  function void add_pair(longint c[3], longint n[3]);
    add_term(0, (c[1] - n[1]) * (c[2] + n[2]));
    add_term(1, (c[2] - n[2]) * (c[0] + n[0]));
    add_term(2, (c[0] - n[0]) * (c[1] + n[1]));
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale the sum so the largest magnitude sits in [2^29, 2^30), then divide by length.
  function normal_t unit_normal();
    normal_t         r;
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned m, sum, len, q;
    int              bl;
    logic signed [pnn_pkg::OUT_W-1:0] comp[3];
    m = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = acc[k] < 0;
      mag[k] = neg[k] ? 64'd0 - longint'(acc[k]) : acc[k];
      if (mag[k] > m) m = mag[k];
    end
    r.sat = sat_sticky;
    if (m == 0) begin
      r.nx = 0;
      r.ny = pnn_pkg::Q15_MAX;
      r.nz = 0;
      r.degen = 1;
      return r;
    end
    bl = 0;
    while ((m >> bl) != 0) bl++;
    for (int k = 0; k < 3; k++) begin
      if (bl < 30) mag[k] = mag[k] << (30 - bl);
      else mag[k] = mag[k] >> (bl - 30);
      sum += mag[k] * mag[k];
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 32768 + (len >> 1)) / len;
      if (q > pnn_pkg::Q15_MAX) q = pnn_pkg::Q15_MAX;
      comp[k] = neg[k] ? -q[15:0] : q[15:0];
    end
    r.nx = comp[0];
    r.ny = comp[1];
    r.nz = comp[2];
    r.degen = 0;
    return r;
  endfunction

  function void note_vertex(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, logic last);
    longint cur[3];
    cur[0] = x;
    cur[1] = y;
    cur[2] = z;
    if (!open_poly) begin
      first_v = cur;
      acc = '{0, 0, 0};
      sat_sticky = 0;
      open_poly = 1;
    end else begin
      add_pair(prev_v, cur);
    end
    prev_v = cur;
    if (last) begin
      add_pair(cur, first_v);
      expected_normals.insert(expected_normals.size(), unit_normal());
      open_poly = 0;
    end
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                    logic signed [15:0] nz, logic degen, logic sat);
    normal_t e;
    if (expected_normals.size() == 0) begin
      report_mismatch("unexpected normal beat, queue", 1, 0);
      return;
    end
    e = expected_normals.pop_front();
    n_polys++;
    n_degen += degen;
    n_sat += sat;
    if (nx !== e.nx) report_mismatch("normal_x", nx, e.nx);
    if (ny !== e.ny) report_mismatch("normal_y", ny, e.ny);
    if (nz !== e.nz) report_mismatch("normal_z", nz, e.nz);
    if (degen !== e.degen) report_mismatch("degenerate", degen, e.degen);
    if (sat !== e.sat) report_mismatch("saturated", sat, e.sat);
  endtask

  function int pending();
    return expected_normals.size();
  endfunction
endclass

module polygon_normal_newell_tb;
  localparam int IDLE_LIMIT = 5000;     // cycles with no beat on either side
  localparam int RANDOM_ITEMS = 750;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = 24'sh800000;

  logic clk;
  logic rst;

  pnn_vtx_if vtx ();
  pnn_nrm_if nrm ();

  polygon_normal_newell dut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx),
    .nrm(nrm)
  );

  normal_scoreboard sb = new();

  int burst_left;
  int idle_cycles;
  int sent;

  initial clk = 0;
  always #5 clk = ~clk;

  // Receiver: ready pattern switches between always-on, random and long stalls.
  int rx_mode;
  int rx_left;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(5, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: nrm.ready <= 1'b1;
      1: nrm.ready <= $urandom_range(0, 1);
      default: nrm.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Output monitor: checks each accepted normal beat.
  always @(posedge clk) begin
    if (!rst && nrm.valid && nrm.ready)
      sb.check_normal(nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate, nrm.saturated);
  end

  // Watchdog: a run stuck with no beats anywhere ends as a failure.
  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (nrm.valid && nrm.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no beat for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One vertex beat. The sender runs in bursts; between bursts valid may drop for a gap.
  task send_vertex(logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z,
                   logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        vtx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    vtx.valid <= 1'b1;
    vtx.pos_x <= x;
    vtx.pos_y <= y;
    vtx.pos_z <= z;
    vtx.last_vertex <= last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    sb.note_vertex(x, y, z, last);
    sent++;
  endtask

  task hold_idle();
    vtx.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic signed [23:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 24'($urandom());
      1: return $signed(24'($urandom_range(0, 128))) - 24'sd64;
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      3: return $signed(24'($urandom())) >>> $urandom_range(0, 20);
      default: return 24'($urandom());
    endcase
  endfunction

  task send_polygon(int nverts);
    for (int i = 0; i < nverts; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), i == nverts - 1);
  endtask

  // Square loop wound many times; the z sum grows far past a single winding.
  task send_winding(int loops);
    for (int i = 0; i < loops; i++) begin
      send_vertex(CMAX, CMAX, 24'sd0, 1'b0);
      send_vertex(CMIN, CMAX, 24'sd0, 1'b0);
      send_vertex(CMIN, CMIN, 24'sd0, 1'b0);
      send_vertex(CMAX, CMIN, 24'sd0, i == loops - 1);
    end
  endtask

  initial begin
    int nv;
    rst = 1'b1;
    vtx.valid = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.last_vertex = 1'b0;
    nrm.ready = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    idle_cycles = 0;
    burst_left = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single vertices close on themselves, giving the fallback normal.
    send_vertex(CMAX, CMAX, CMAX, 1'b1);
    send_vertex(CMIN, CMIN, CMIN, 1'b1);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1);
    // Extreme triangle, and its reverse winding.
    send_vertex(CMAX, CMIN, CMAX, 1'b0);
    send_vertex(CMIN, CMAX, CMAX, 1'b0);
    send_vertex(CMAX, CMAX, CMIN, 1'b1);
    send_vertex(CMAX, CMAX, CMIN, 1'b0);
    send_vertex(CMIN, CMAX, CMAX, 1'b0);
    send_vertex(CMAX, CMIN, CMAX, 1'b1);
    // Tiny triangle: small sum, scaled up before the root.
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd1, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd0, 24'sd1, 24'sd0, 1'b1);
    // Collinear points: zero area.
    send_vertex(24'sd10, 24'sd20, 24'sd30, 1'b0);
    send_vertex(24'sd20, 24'sd40, 24'sd60, 1'b0);
    send_vertex(24'sd30, 24'sd60, 24'sd90, 1'b1);
    // Axis-aligned unit square in the xz plane.
    send_vertex(24'sd0, 24'sd5, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd5, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd5, 24'sd4096, 1'b0);
    send_vertex(24'sd0, 24'sd5, 24'sd4096, 1'b1);
    // Sender holds off until every normal has been returned.
    hold_idle();
    // Large wound sum, shifted right by the normaliser.
    send_winding(32);
    hold_idle();

    // Random: mostly closed polygons, some long ones, and some stray last flags.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          nv = $urandom_range(1, 4);
          for (int i = 0; i < nv; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
        end
        1: send_polygon($urandom_range(12, 40));
        default: send_polygon($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 60) == 0) hold_idle();
    end
    // Close any polygon left open by the stray flags.
    send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    vtx.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Run covered %0d normals (%0d degenerate, %0d saturated) under random stalls.",
             sb.n_polys, sb.n_degen, sb.n_sat);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d normals outstanding", sb.errors, sb.pending());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/pnn_pkg.sv
src/pnn_if.sv
src/pnn_front.sv
src/pnn_queue.sv
src/pnn_back.sv
src/polygon_normal_newell.sv
sim/polygon_normal_newell_tb.sv
